[hdl/u8sd_pkg.sv]
// ----------------------------------------------------------------------------
// u8sd_pkg
// Types and constants shared by the streaming UTF-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8sd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CP_W        = 21;
  localparam int TOTAL_W     = 16;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LEAD   = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [2:0]         seq_length;
    status_t            status;
    logic [TOTAL_W-1:0] char_total;
    logic [TOTAL_W-1:0] byte_total;
    logic               is_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]             bytes_pending;
    logic [2:0]             seq_len;
    logic [CP_W-1:0]        code_accum;
    logic [COUNT_WIDTH-1:0] char_cnt;
    logic [COUNT_WIDTH-1:0] byte_cnt;
  } dec_state_t;

endpackage

`default_nettype wire

[hdl/u8sd_step.sv]
// ----------------------------------------------------------------------------
// u8sd_step
// Decodes one byte against the current sequence state and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module u8sd_step (
  input  wire u8sd_pkg::dec_state_t st,
  input  wire u8sd_pkg::in_item_t   item,
  input  wire                       utf8_mode,
  output u8sd_pkg::dec_state_t      st_nxt,
  output logic                      emit,
  output u8sd_pkg::out_item_t       res
);
  import u8sd_pkg::*;

  logic [COUNT_WIDTH-1:0] byte_cnt_inc;
  logic [COUNT_WIDTH-1:0] char_cnt_inc;
  logic [CP_W-1:0]        acc_shift;
  logic [7:0]             b;
  logic                   last;
  logic                   char_done;
  logic [CP_W-1:0]        code;
  logic [2:0]             len;
  status_t                status;

  assign b    = item.byte_in;
  assign last = item.end_of_text;

  assign byte_cnt_inc = (st.byte_cnt == COUNT_MAX) ? st.byte_cnt : st.byte_cnt + 1'b1;
  assign char_cnt_inc = (st.char_cnt == COUNT_MAX) ? st.char_cnt : st.char_cnt + 1'b1;
  assign acc_shift    = {st.code_accum[CP_W-7:0], b[5:0]};

  always_comb begin
    st_nxt          = st;
    st_nxt.byte_cnt = byte_cnt_inc;
    emit            = 1'b0;
    char_done       = 1'b0;
    code            = '0;
    len             = 3'd0;
    status          = ST_OK;
    if (!utf8_mode) begin
      st_nxt.bytes_pending = 2'd0;
      st_nxt.seq_len       = 3'd0;
      st_nxt.code_accum    = '0;
      emit                 = 1'b1;
      char_done            = 1'b1;
      code                 = CP_W'(b);
      len                  = 3'd1;
    end else if (st.bytes_pending != 2'd0) begin
      st_nxt.code_accum    = acc_shift;
      st_nxt.bytes_pending = st.bytes_pending - 2'd1;
      if (st.bytes_pending == 2'd1) begin
        emit      = 1'b1;
        char_done = 1'b1;
        code      = acc_shift;
        len       = st.seq_len;
      end else if (last) begin
        emit   = 1'b1;
        len    = st.seq_len;
        status = ST_INCOMPLETE;
      end
      if (emit) begin
        st_nxt.bytes_pending = 2'd0;
        st_nxt.seq_len       = 3'd0;
        st_nxt.code_accum    = '0;
      end
    end else begin
      priority if (b <= 8'h7F) begin
        emit      = 1'b1;
        char_done = 1'b1;
        code      = CP_W'(b);
        len       = 3'd1;
      end else if (b <= 8'hBF || b >= 8'hF8) begin
        emit   = 1'b1;
        status = ST_BAD_LEAD;
      end else begin
        priority if (b <= 8'hDF) begin
          len               = 3'd2;
          st_nxt.code_accum = CP_W'(b[4:0]);
        end else if (b <= 8'hEF) begin
          len               = 3'd3;
          st_nxt.code_accum = CP_W'(b[3:0]);
        end else begin
          len               = 3'd4;
          st_nxt.code_accum = CP_W'(b[2:0]);
        end
        if (last) begin
          emit                 = 1'b1;
          status               = ST_INCOMPLETE;
          st_nxt.code_accum    = '0;
        end else begin
          st_nxt.seq_len       = len;
          st_nxt.bytes_pending = 2'(len - 3'd1);
        end
      end
    end
    if (char_done) begin
      st_nxt.char_cnt = char_cnt_inc;
    end
  end

  assign res.code_point = code;
  assign res.seq_length = len;
  assign res.status     = status;
  assign res.char_total = TOTAL_W'(st_nxt.char_cnt);
  assign res.byte_total = TOTAL_W'(st_nxt.byte_cnt);
  assign res.is_last    = last;

endmodule

`default_nettype wire

[hdl/utf8_stream_decoder_core.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// Streaming UTF-8 decoder with saturating character and byte totals.
//
//   Port group  Direction  Handshake        Payload
//   in_*        input      in_valid/ready   u8sd_pkg::in_item_t
//   out_*       output     out_valid/ready  u8sd_pkg::out_item_t
//   cfg_*       input      cfg_we           utf8_mode bit
//
// One byte per clock is accepted while in_ready is high. A byte is held in
// the input register and is decoded into the result register when the stage
// advances; out_valid and out_data come from the result register. Reset clears
// the sequence state and totals and sets utf8_mode. When the result register
// is held by a stalled consumer, the input stage stops once it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_decoder_core (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire u8sd_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire                       out_ready,
  output u8sd_pkg::out_item_t       out_data,
  input  wire                       cfg_we,
  input  wire                       cfg_wdata
);
  import u8sd_pkg::*;

  logic       mode_r;
  logic       s1_valid_r;
  in_item_t   s1_item_r;
  dec_state_t st_r;
  dec_state_t st_nxt;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       emit;
  out_item_t  res;
  logic       advance;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  u8sd_step u_step (
    .st        (st_r),
    .item      (s1_item_r),
    .utf8_mode (mode_r),
    .st_nxt    (st_nxt),
    .emit      (emit),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= 1'b1;
      s1_valid_r  <= 1'b0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        st_r        <= st_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (advance && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[tb/utf8_stream_decoder_core_tb.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core_tb
// Self-checking bench for the streaming UTF-8 decoder. A scoreboard class
// tracks the decoder state and predicts each result from the accepted bytes.
// It checks each received result field by field against the oldest
// prediction. The stimulus runs directed corner cases and randomized text in
// both modes with random stalls on both sides, then a tail without stalls.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8sd_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 48;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int PHASE_BYTES   = 500;
  localparam int TAIL_BYTES    = 250;

  class utf8_char_tracker;
    bit                     mode;
    logic [1:0]             cont_left;
    logic [2:0]             open_len;
    logic [CP_W-1:0]        code_acc;
    logic [COUNT_WIDTH-1:0] n_chars;
    logic [COUNT_WIDTH-1:0] n_bytes;
    out_item_t              due_chars[$];
    int                     n_errors;

    function new();
      mode      = 1'b1;
      cont_left = '0;
      open_len  = '0;
      code_acc  = '0;
      n_chars   = '0;
      n_bytes   = '0;
      n_errors  = 0;
    endfunction

    function logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] c);
      return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function void drop_sequence();
      cont_left = '0;
      open_len  = '0;
      code_acc  = '0;
    endfunction

    function void push_char(logic [CP_W-1:0] cp, logic [2:0] len, status_t st,
                            logic last);
      out_item_t r;
      r.code_point = cp;
      r.seq_length = len;
      r.status     = st;
      r.char_total = n_chars[TOTAL_W-1:0];
      r.byte_total = n_bytes[TOTAL_W-1:0];
      r.is_last    = last;
      due_chars.push_back(r);
    endfunction

    function void note_byte(in_item_t it);
      logic [7:0]      b;
      logic [2:0]      len;
      logic [CP_W-1:0] cp;
      b = it.byte_in;
      n_bytes = sat_inc(n_bytes);
      if (!mode) begin
        drop_sequence();
        n_chars = sat_inc(n_chars);
        push_char(CP_W'(b), 3'd1, ST_OK, it.end_of_text);
      end else if (cont_left != 0) begin
        code_acc  = {code_acc[CP_W-7:0], b[5:0]};
        cont_left = cont_left - 1'b1;
        if (cont_left == 0) begin
          cp  = code_acc;
          len = open_len;
          drop_sequence();
          n_chars = sat_inc(n_chars);
          push_char(cp, len, ST_OK, it.end_of_text);
        end else if (it.end_of_text) begin
          len = open_len;
          drop_sequence();
          push_char('0, len, ST_INCOMPLETE, 1'b1);
        end
      end else if (b < 8'h80) begin
        n_chars = sat_inc(n_chars);
        push_char(CP_W'(b), 3'd1, ST_OK, it.end_of_text);
      end else if (b < 8'hC0 || b >= 8'hF8) begin
        push_char('0, 3'd0, ST_BAD_LEAD, it.end_of_text);
      end else begin
        if (b < 8'hE0) begin
          len = 3'd2;
          cp  = CP_W'(b[4:0]);
        end else if (b < 8'hF0) begin
          len = 3'd3;
          cp  = CP_W'(b[3:0]);
        end else begin
          len = 3'd4;
          cp  = CP_W'(b[2:0]);
        end
        if (it.end_of_text) begin
          drop_sequence();
          push_char('0, len, ST_INCOMPLETE, 1'b1);
        end else begin
          open_len  = len;
          cont_left = 2'(len - 3'd1);
          code_acc  = cp;
        end
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_char(out_item_t got);
      out_item_t want;
      if (due_chars.size() == 0) begin
        $error("unexpected result: code_point 0x%0h status %0d", got.code_point,
               got.status);
        n_errors++;
      end else begin
        want = due_chars.pop_front();
        check_field("code_point", 32'(want.code_point), 32'(got.code_point));
        check_field("seq_length", 32'(want.seq_length), 32'(got.seq_length));
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("char_total", 32'(want.char_total), 32'(got.char_total));
        check_field("byte_total", 32'(want.byte_total), 32'(got.byte_total));
        check_field("is_last", 32'(want.is_last), 32'(got.is_last));
      end
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  utf8_char_tracker tracker;
  int unsigned      idle_cycles = 0;
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  bit               long_hold_req = 1'b0;

  utf8_stream_decoder_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready) begin
      tracker.check_char(out_data);
    end
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_MAX);
    $display("utf8_stream_decoder_core_tb: done, errors");
    $finish;
  end

  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) begin
      return 8'($urandom);
    end
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic end_flag();
    return $urandom_range(0, 29) == 0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{byte_in: b, end_of_text: last};
    do @(posedge clk); while (in_ready !== 1'b1);
    tracker.note_byte('{byte_in: b, end_of_text: last});
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_chars.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input bit m);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.mode = m;
  endtask

  task automatic send_text_piece(output int n);
    int         pick;
    int         conts;
    logic [7:0] lead;
    pick  = $urandom_range(0, 99);
    conts = 0;
    if (pick < 35) begin
      lead = 8'($urandom_range(0, 127));
    end else if (pick < 55) begin
      lead  = 8'hC0 | 8'($urandom_range(0, 31));
      conts = 1;
    end else if (pick < 70) begin
      lead  = 8'hE0 | 8'($urandom_range(0, 15));
      conts = 2;
    end else if (pick < 80) begin
      lead  = 8'hF0 | 8'($urandom_range(0, 7));
      conts = 3;
    end else if (pick < 84) begin
      lead = 8'($urandom_range(8'h80, 8'hBF));
    end else if (pick < 88) begin
      lead = 8'($urandom_range(8'hF8, 8'hFF));
    end else if (pick < 94) begin
      lead  = 8'($urandom_range(8'hC0, 8'hF7));
      conts = $urandom_range(0, (lead < 8'hE0) ? 0 : (lead < 8'hF0) ? 1 : 2);
    end else begin
      lead = 8'($urandom);
    end
    send_byte(lead, end_flag());
    for (int i = 0; i < conts; i++) begin
      send_byte(cont_byte(), end_flag());
    end
    n = conts + 1;
  endtask

  initial begin : stimulus
    int sent;
    int piece;
    bit hold_done;
    bit pause_done;
    bit phase_mode[3];
    int phase_tx[3];
    int phase_rx[3];
    tracker    = new();
    hold_done  = 1'b0;
    pause_done = 1'b0;
    phase_mode = '{1'b1, 1'b0, 1'b1};
    phase_tx   = '{15, 30, 5};
    phase_rx   = '{20, 10, 35};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 10;
    rx_idle_pct = 10;
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hF0, 1'b1);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h80, 1'b0);
    set_mode(1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hFF, 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      set_mode(phase_mode[ph]);
      tx_idle_pct = phase_tx[ph];
      rx_idle_pct = phase_rx[ph];
      sent = 0;
      while (sent < PHASE_BYTES) begin
        if (ph == 0 && !hold_done && sent >= 200) begin
          hold_done     = 1'b1;
          long_hold_req = 1'b1;
        end
        if (ph == 1 && !pause_done && sent >= 300) begin
          pause_done = 1'b1;
          wait_drained();
        end
        send_text_piece(piece);
        sent += piece;
      end
    end

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_mode(1'b1);
    sent = 0;
    while (sent < TAIL_BYTES) begin
      send_text_piece(piece);
      sent += piece;
    end

    wait_drained();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (tracker.n_errors == 0 && tracker.due_chars.size() == 0) begin
      $display("utf8_stream_decoder_core_tb: done, clean");
    end else begin
      $display("utf8_stream_decoder_core_tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
hdl/u8sd_pkg.sv
hdl/u8sd_step.sv
hdl/utf8_stream_decoder_core.sv
tb/utf8_stream_decoder_core_tb.sv
